FILE: rtl/core/lfa32_pkg.sv
// ----------------------------------------------------------------------------
// lfa32_pkg
// Shared types and constants for the length-prefixed frame Adler-32 checker.
// ----------------------------------------------------------------------------
package lfa32_pkg;

  // Frame layout
  localparam int unsigned HeaderBytes   = 4;
  localparam int unsigned ChecksumBytes = 4;
  localparam int unsigned MaxTagBytes   = 8;

  // Register file layout
  localparam int unsigned LenWidth    = 27;
  localparam int unsigned TagLenWidth = 4;
  localparam int unsigned TagWidth    = 64;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 64;

  // Default depth of the request queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // Adler-32 modulus
  localparam logic [16:0] AdlerMod = 17'd65521;

  // Register reset values
  localparam logic [LenWidth-1:0] MinLengthReset = 27'd6;
  localparam logic [LenWidth-1:0] MaxLengthReset = 27'd67108864;

  // Register indices
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MIN_LENGTH = 2'd0,
    CFG_MAX_LENGTH = 2'd1,
    CFG_TAG_LENGTH = 2'd2,
    CFG_TAG_BYTES  = 2'd3
  } cfg_idx_e;

  // Verdict codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEN   = 2'd1,
    ST_CKSUM_ERR = 2'd2,
    ST_BAD_TYPE  = 2'd3
  } status_e;

  // Result kinds
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  // Requests passed from front to back
  typedef enum logic [1:0] {
    OP_PAYLOAD = 2'd0,
    OP_TAG     = 2'd1,
    OP_TRAILER = 2'd2,
    OP_LEN_ERR = 2'd3
  } op_e;

  // Deframer phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_BODY    = 3'b010,
    PH_TRAILER = 3'b100
  } phase_e;

  // Live configuration seen by the front
  typedef struct packed {
    logic [LenWidth-1:0]    min_length;
    logic [LenWidth-1:0]    max_length;
    logic [TagLenWidth-1:0] tag_len;     // already clamped to MaxTagBytes
    logic [TagWidth-1:0]    tag_bytes;
  } cfg_t;

  // One queued request
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last;     // final checksum byte of the frame
    logic       tag_err;  // tag differed, valid with last
  } req_t;

endpackage

FILE: rtl/core/lfa32_queue.sv
// ----------------------------------------------------------------------------
// lfa32_queue
// Small request FIFO that decouples the deframing front from the check back.
// ----------------------------------------------------------------------------
module lfa32_queue
  import lfa32_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_req_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output req_t pop_req_o,
  input  logic pop_i
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);

  req_t                mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != DepthCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_req_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

`ifndef SYNTHESIS
  // Fill count never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt) else $error("queue overfilled");

  // A push and pop on a non-empty queue leaves the count unchanged
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && do_pop) |=> (count_q == $past(count_q)))
    else $error("queue count drifted");
`endif

endmodule

FILE: rtl/core/lfa32_front.sv
// ----------------------------------------------------------------------------
// lfa32_front
// Takes stream bytes, tracks the frame layout, checks the length and the tag,
// and issues one request per byte that the back has to see.
// ----------------------------------------------------------------------------
module lfa32_front
  import lfa32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       push_o,
  output req_t       push_req_o,
  input  logic       push_ready_i
);

  phase_e              phase_q, phase_d;
  logic [1:0]          cnt_q, cnt_d;         // header / trailer byte count
  logic [23:0]         len_shift_q, len_shift_d;
  logic [LenWidth-1:0] frame_len_q, frame_len_d;
  logic [LenWidth-1:0] body_cnt_q, body_cnt_d;
  logic                tag_mis_q, tag_mis_d;
  logic                halted_q, halted_d;

  logic                accept;
  logic [31:0]         len_word;
  logic                len_bad;
  logic                is_tag;
  logic [3:0]          tag_sel;
  logic [7:0]          tag_want;
  logic                body_end;
  logic                cnt_last;

  // Once halted, bytes are taken and dropped
  assign in_ready_o = push_ready_i | halted_q;
  assign accept     = in_valid_i & in_ready_o;
  assign cnt_last   = (cnt_q == 2'(HeaderBytes - 1));

  // Length check on the completed header
  assign len_word = {len_shift_q, byte_in_i};
  assign len_bad  = (len_word > {5'd0, cfg_i.max_length})
                 || (len_word < {5'd0, cfg_i.min_length})
                 || (len_word < ({28'd0, cfg_i.tag_len} + 32'(ChecksumBytes)));

  // Tag byte selection, first tag byte in the highest used position
  assign is_tag   = (body_cnt_q < {23'd0, cfg_i.tag_len});
  assign tag_sel  = cfg_i.tag_len - 4'd1 - body_cnt_q[3:0];
  assign tag_want = cfg_i.tag_bytes[{tag_sel[2:0], 3'b000} +: 8];
  assign body_end = ((body_cnt_q + 1'b1) >= (frame_len_q - LenWidth'(ChecksumBytes)));

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_shift_d = len_shift_q;
    frame_len_d = frame_len_q;
    body_cnt_d  = body_cnt_q;
    tag_mis_d   = tag_mis_q;
    halted_d    = halted_q;
    push_o      = 1'b0;
    push_req_o  = '{op: OP_PAYLOAD, data: byte_in_i, last: 1'b0, tag_err: tag_mis_q};
    if (accept && !halted_q) begin
      case (phase_q)
        PH_HEADER: begin
          len_shift_d = len_word[23:0];
          cnt_d       = cnt_q + 1'b1;
          if (cnt_last) begin
            cnt_d = '0;
            if (len_bad) begin
              push_o         = 1'b1;
              push_req_o.op  = OP_LEN_ERR;
              halted_d       = 1'b1;
            end else begin
              frame_len_d = len_word[LenWidth-1:0];
              body_cnt_d  = '0;
              phase_d     = (len_word == 32'(ChecksumBytes)) ? PH_TRAILER : PH_BODY;
            end
          end
        end
        PH_BODY: begin
          push_o        = 1'b1;
          push_req_o.op = is_tag ? OP_TAG : OP_PAYLOAD;
          if (is_tag && (tag_want != byte_in_i)) begin
            tag_mis_d = 1'b1;
          end
          body_cnt_d = body_cnt_q + 1'b1;
          if (body_end) begin
            body_cnt_d = '0;
            phase_d    = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          push_o          = 1'b1;
          push_req_o.op   = OP_TRAILER;
          push_req_o.last = cnt_last;
          cnt_d           = cnt_q + 1'b1;
          if (cnt_last) begin
            // Next frame starts; the back decides whether it still counts
            cnt_d       = '0;
            phase_d     = PH_HEADER;
            len_shift_d = '0;
            tag_mis_d   = 1'b0;
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cnt_q       <= '0;
      len_shift_q <= '0;
      frame_len_q <= '0;
      body_cnt_q  <= '0;
      tag_mis_q   <= 1'b0;
      halted_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      len_shift_q <= len_shift_d;
      frame_len_q <= frame_len_d;
      body_cnt_q  <= body_cnt_d;
      tag_mis_q   <= tag_mis_d;
      halted_q    <= halted_d;
    end
  end

`ifndef SYNTHESIS
  // Body count stays inside the frame body
  a_body_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (body_cnt_q < frame_len_q))
    else $error("body count past frame end");

  // A length error always halts the front
  a_len_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_req_o.op == OP_LEN_ERR) |=> halted_q)
    else $error("length error without halt");

  // Tag mismatch is clear at the start of each frame
  a_tag_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER && cnt_q == 2'd0) |-> !tag_mis_q)
    else $error("stale tag mismatch");
`endif

endmodule

FILE: rtl/core/lfa32_back.sv
// ----------------------------------------------------------------------------
// lfa32_back
// Runs the Adler-32 sums, checks the trailer, and holds the result register.
// ----------------------------------------------------------------------------
module lfa32_back
  import lfa32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  req_t       req_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] data_out_o,
  output logic [1:0] status_o
);

  logic [15:0] adler_low_q, adler_low_d;
  logic [15:0] adler_high_q, adler_high_d;
  logic [23:0] trl_shift_q, trl_shift_d;
  logic        halted_q, halted_d;
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  status_e     status_q, status_d;

  logic        advance;
  logic [16:0] sum_low, sum_high;
  logic [15:0] new_low, new_high;
  logic [31:0] trl_word;

  // Take a request whenever the result register is free or draining
  assign advance = req_valid_i & (~out_valid_q | out_ready_i);
  assign pop_o   = advance;

  // Adler-32 step: two modular additions
  assign sum_low  = {1'b0, adler_low_q} + {9'd0, req_i.data};
  assign new_low  = (sum_low >= AdlerMod) ? 16'(sum_low - AdlerMod) : sum_low[15:0];
  assign sum_high = {1'b0, adler_high_q} + {1'b0, new_low};
  assign new_high = (sum_high >= AdlerMod) ? 16'(sum_high - AdlerMod) : sum_high[15:0];
  assign trl_word = {trl_shift_q, req_i.data};

  always_comb begin
    adler_low_d  = adler_low_q;
    adler_high_d = adler_high_q;
    trl_shift_d  = trl_shift_q;
    halted_d     = halted_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    kind_d       = kind_q;
    data_d       = data_q;
    status_d     = status_q;
    if (advance && !halted_q) begin
      case (req_i.op)
        OP_PAYLOAD: begin
          adler_low_d  = new_low;
          adler_high_d = new_high;
          out_valid_d  = 1'b1;
          kind_d       = KIND_PAYLOAD;
          data_d       = req_i.data;
          status_d     = ST_OK;
        end
        OP_TAG: begin
          adler_low_d  = new_low;
          adler_high_d = new_high;
        end
        OP_TRAILER: begin
          trl_shift_d = trl_word[23:0];
          if (req_i.last) begin
            out_valid_d = 1'b1;
            kind_d      = KIND_VERDICT;
            data_d      = '0;
            if (trl_word != {adler_high_q, adler_low_q}) begin
              status_d = ST_CKSUM_ERR;
              halted_d = 1'b1;
            end else if (req_i.tag_err) begin
              status_d = ST_BAD_TYPE;
              halted_d = 1'b1;
            end else begin
              status_d = ST_OK;
            end
            adler_low_d  = 16'd1;
            adler_high_d = '0;
            trl_shift_d  = '0;
          end
        end
        OP_LEN_ERR: begin
          out_valid_d = 1'b1;
          kind_d      = KIND_VERDICT;
          data_d      = '0;
          status_d    = ST_BAD_LEN;
          halted_d    = 1'b1;
        end
        default: begin
          halted_d = halted_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adler_low_q  <= 16'd1;
      adler_high_q <= '0;
      trl_shift_q  <= '0;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      adler_low_q  <= adler_low_d;
      adler_high_q <= adler_high_d;
      trl_shift_q  <= trl_shift_d;
      halted_q     <= halted_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    data_q   <= data_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_out_o  = data_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt released");

  // Both sums stay reduced
  a_adler_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adler_low_q < AdlerMod[15:0]) && (adler_high_q < AdlerMod[15:0]))
    else $error("adler sum out of range");

  // A verdict that is not ok is followed by halt
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && kind_q == KIND_VERDICT && status_q != ST_OK) |-> halted_q)
    else $error("error verdict without halt");
`endif

endmodule

FILE: rtl/core/length_frame_adler32_checker_unit.sv
// ----------------------------------------------------------------------------
// length_frame_adler32_checker_unit
// Deframes a byte stream of length-prefixed frames and checks each Adler-32.
// ----------------------------------------------------------------------------
// Input channel: one received byte per request (in_valid_i / in_ready_o).
// Output channel: one result per request (out_valid_o / out_ready_i); kind_o
// is 0 for a payload byte in data_out_o, 1 for a frame verdict in status_o
// (0 ok, 1 invalid length, 2 checksum error, 3 unknown message type).
// Header, tag and leading checksum bytes give no result.
// Throughput is one byte per cycle while the queue has room; the Adler-32
// update in the back stage (two modular additions) sets that figure. An
// accepted byte passes the queue storage and the result register to its result.
// A queue of QueueDepth requests sits between the deframing front and the
// checking back, so the input keeps flowing while a result waits.
// When the receiver stalls, the queue fills and in_ready_o drops.
// After any error verdict, further bytes are taken and dropped until reset.
// Reset (rst_ni low, asynchronous) clears all frame state and loads the
// register defaults: min length 6, max length 2^26, no tag.
// Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i.
// ----------------------------------------------------------------------------
module length_frame_adler32_checker_unit
  import lfa32_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             byte_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   kind_o,
  output logic [7:0]             data_out_o,
  output logic [1:0]             status_o
);

  logic [LenWidth-1:0]    min_len_q;
  logic [LenWidth-1:0]    max_len_q;
  logic [TagLenWidth-1:0] tag_len_q;
  logic [TagWidth-1:0]    tag_bytes_q;
  cfg_t                   cfg;

  logic push, push_ready, pop, pop_valid;
  req_t push_req, pop_req;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q   <= MinLengthReset;
      max_len_q   <= MaxLengthReset;
      tag_len_q   <= '0;
      tag_bytes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_LENGTH: min_len_q   <= cfg_wdata_i[LenWidth-1:0];
        CFG_MAX_LENGTH: max_len_q   <= cfg_wdata_i[LenWidth-1:0];
        CFG_TAG_LENGTH: tag_len_q   <= cfg_wdata_i[TagLenWidth-1:0];
        CFG_TAG_BYTES:  tag_bytes_q <= cfg_wdata_i[TagWidth-1:0];
        default:        tag_len_q   <= tag_len_q;
      endcase
    end
  end

  // Oversized tag lengths clamp to the maximum
  always_comb begin
    cfg.min_length = min_len_q;
    cfg.max_length = max_len_q;
    cfg.tag_len    = (tag_len_q > TagLenWidth'(MaxTagBytes))
                   ? TagLenWidth'(MaxTagBytes) : tag_len_q;
    cfg.tag_bytes  = tag_bytes_q;
  end

  lfa32_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .push_o       (push),
    .push_req_o   (push_req),
    .push_ready_i (push_ready)
  );

  lfa32_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_req_i   (push_req),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_req_o    (pop_req),
    .pop_i        (pop)
  );

  lfa32_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (pop_valid),
    .req_i       (pop_req),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_out_o  (data_out_o),
    .status_o    (status_o)
  );

endmodule
